[rtl/polyphase_pcm_upsampler_defines.svh]
// Assertion macros shared by the upsampler checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef POLYPHASE_PCM_UPSAMPLER_DEFINES_SVH
`define POLYPHASE_PCM_UPSAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PPU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PPU_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ppu_pkg.sv]
// Package for the polyphase upsampler: widths, register map, chain tag type,
// and the elaboration-time windowed-sinc coefficient generator. No dependencies.
`timescale 1ns / 1ps

package ppu_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FACTOR_W    = 3;
    localparam int PHASE_W     = 3;
    localparam int CLIP_W      = 32;
    localparam int OUT_DATA_W  = SAMPLE_W + CLIP_W;
    localparam int OUT_USER_W  = PHASE_W + 1;
    localparam int ROM_ADDR_W  = FACTOR_W + PHASE_W;

    localparam int DEF_TAP_COUNT      = 16;
    localparam int DEF_MAX_FACTOR     = 6;
    localparam int DEF_OUTPUT_DIVISOR = 1;
    localparam int DEF_COEF_BITS      = 18;

    localparam int SAMPLE_MAX  = 32767;
    localparam int SAMPLE_MIN_MAG = 32768;
    localparam int CENTER_TAP  = 8;
    localparam int WINDOW_HALF = 8;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_UPSAMPLE_FACTOR = '0;

    // Control tag that travels down the tap chain beside the partial sum
    typedef struct packed {
        logic               valid;
        logic [PHASE_W-1:0] phase;
        logic               last;
    } ppu_tag_t;

    // Long division by shift and subtract; elaboration use only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int          i;
        quo = '0;
        rem = '0;
        if (den == 64'd0)
        begin
            return '0;
        end
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(pi*m/d) in Q30 by a truncated Taylor series
    function automatic logic [63:0] sine_q30(input logic [63:0] m_in, input logic [63:0] d);
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int          k;
        m = m_in;
        if (d == 64'd0 || m >= d)
        begin
            return '0;
        end
        if ((m << 1) > d)
        begin
            m = d - m;
        end
        x    = udiv64(PI_Q30 * m, d);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (k = 1; k <= 7; k++)
        begin
            term = udiv64((term * x2) >> 30, 64'(2 * k * (2 * k + 1)));
            if (k[0])
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30))
        begin
            sum = longint'(1) << 30;
        end
        return 64'(sum);
    endfunction

    function automatic logic signed [31:0] coef_round(input logic [63:0] mag, input logic neg,
                                                      input logic [63:0] den_in,
                                                      input int frac, input int cbits);
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] lim;
        den = (den_in == 64'd0) ? 64'd1 : den_in;
        q   = udiv64((mag << frac) + (den >> 1), den);
        lim = neg ? (64'd1 << (cbits - 1)) : ((64'd1 << (cbits - 1)) - 64'd1);
        if (q > lim)
        begin
            q = lim;
        end
        return neg ? -signed'(q[31:0]) : signed'(q[31:0]);
    endfunction

    // Coefficient of tap j, phase p, factor f in signed Q2.(cbits-2)
    function automatic logic signed [31:0] coef_value(input int taps, input int cbits,
                                                      input int odiv, input int f,
                                                      input int p, input int j);
        int          jj;
        int          n;
        int          an;
        logic [63:0] w;
        logic [63:0] wj;
        logic        ng;
        logic        ngj;
        longint      sum;
        logic [63:0] den;
        if (f < 1 || p >= f)
        begin
            return '0;
        end
        if (p == 0)
        begin
            return (j == CENTER_TAP) ? coef_round(64'd1, 1'b0, 64'(odiv), cbits - 2, cbits)
                                     : 32'sd0;
        end
        sum = 0;
        wj  = '0;
        ngj = 1'b0;
        for (jj = 0; jj < taps; jj++)
        begin
            n  = (jj - CENTER_TAP) * f + p;
            an = (n < 0) ? -n : n;
            w  = '0;
            ng = 1'b0;
            if (an < WINDOW_HALF * f && an != 0)
            begin
                w  = udiv64(sine_q30(64'(an), 64'(WINDOW_HALF * f)) << 10, 64'(an * an));
                ng = (jj[0] != (n < 0));
                sum = ng ? sum - longint'(w) : sum + longint'(w);
            end
            if (jj == j)
            begin
                wj  = w;
                ngj = ng;
            end
        end
        den = (sum > 0) ? 64'(sum) * 64'(odiv) : 64'd1;
        return coef_round(wj, ngj, den, cbits - 2, cbits);
    endfunction

endpackage

[rtl/polyphase_pcm_upsampler.sv]
// Top level of the polyphase PCM upsampler: APB register, phase issue
// control, the tap-cell chain and the output stage. Uses ppu_pkg, ppu_tap_cell, ppu_out_stage.
//
//   port group   dir   carries
//   ----------   ---   -------------------------------------------------------
//   s_t*         in    one PCM sample per request (sample_in)
//   m_t*         out   one interpolated sample per phase, tlast on the final phase
//   p*           cfg   APB register 0: upsample_factor (1..MAX_FACTOR)
//
// Input ready returns only once the final phase of an accepted sample has
// reached the output register, so requests are not taken while one is in
// flight: the phases enter the tap chain one after another and each crosses
// one cell per advancing cycle.
// A stalled output freezes the whole chain and the phase issue.
// Reset clears the history, the clip total and sets the factor to 1; a valid
// factor write clears the history and the clip total as well.
`timescale 1ns / 1ps

module polyphase_pcm_upsampler
    import ppu_pkg::*;
#(
    parameter int TAP_COUNT      = DEF_TAP_COUNT,
    parameter int MAX_FACTOR     = DEF_MAX_FACTOR,
    parameter int OUTPUT_DIVISOR = DEF_OUTPUT_DIVISOR,
    parameter int COEF_BITS      = DEF_COEF_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] sample_out, [47:16] clip_total
    output logic [OUT_USER_W-1:0] m_tuser,   // [2:0] phase_index, [3] clipped
    output logic                  m_tlast,   // last
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Sum of TAP_COUNT products of a sample and a coefficient
    localparam int ACC_W = SAMPLE_W + COEF_BITS + $clog2(TAP_COUNT);

    logic [FACTOR_W-1:0]  factor_reg;
    logic [FACTOR_W-1:0]  factor_m1;
    logic                 busy_reg;
    logic                 issuing_reg;
    logic [PHASE_W-1:0]   issue_phase_reg;

    logic                 in_accept;
    logic                 advance;
    logic                 cfg_write;
    logic                 factor_write;
    logic [FACTOR_W-1:0]  wr_factor;
    logic [REG_IDX_W-1:0] reg_index;
    ppu_tag_t             issue_tag;

    logic signed [SAMPLE_W-1:0] tap_link [TAP_COUNT+1];
    logic signed [ACC_W-1:0]    acc_link [TAP_COUNT+1];
    ppu_tag_t                   tag_link [TAP_COUNT+1];

    // ---------------------------------------------------------------
    // APB register: only upsample_factor; out-of-range values are dropped
    // ---------------------------------------------------------------
    assign pready       = 1'b1;
    assign reg_index    = paddr[APB_ADDR_W-1:2];
    assign cfg_write    = psel && penable && pwrite && pready;
    assign wr_factor    = pwdata[FACTOR_W-1:0];
    assign factor_write = cfg_write && (reg_index == REG_UPSAMPLE_FACTOR)
                          && (wr_factor != '0) && (wr_factor <= FACTOR_W'(MAX_FACTOR));

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_UPSAMPLE_FACTOR)
        begin
            prdata = APB_DATA_W'(factor_reg);
        end
    end

    assign factor_m1 = factor_reg - FACTOR_W'(1);

    // ---------------------------------------------------------------
    // Intake and phase issue. One sample in flight at a time: take a new
    // sample only once its last phase has reached the output register.
    // Advance the chain whenever the output register can take a result.
    // ---------------------------------------------------------------
    assign s_tready  = !busy_reg;
    assign in_accept = s_tvalid && s_tready;
    assign advance   = !m_tvalid || m_tready;

    always_comb
    begin
        issue_tag.valid = issuing_reg;
        issue_tag.phase = issue_phase_reg;
        issue_tag.last  = (issue_phase_reg == factor_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg      <= FACTOR_W'(1);
            busy_reg        <= 1'b0;
            issuing_reg     <= 1'b0;
            issue_phase_reg <= '0;
        end
        else
        begin
            if (factor_write)
            begin
                factor_reg <= wr_factor;
            end

            if (in_accept)
            begin
                busy_reg        <= 1'b1;
                issuing_reg     <= 1'b1;
                issue_phase_reg <= '0;
            end
            else
            begin
                // Step through the phases, one per advancing cycle
                if (advance && issuing_reg)
                begin
                    if (issue_tag.last)
                    begin
                        issuing_reg <= 1'b0;
                    end
                    else
                    begin
                        issue_phase_reg <= issue_phase_reg + PHASE_W'(1);
                    end
                end
                // Drop busy once the final phase lands in the output register
                if (advance && tag_link[TAP_COUNT].valid && tag_link[TAP_COUNT].last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tap chain: the history shifts one cell on each accepted sample; the
    // partial sum of each phase walks one cell per advancing cycle beside its tag.
    // ---------------------------------------------------------------
    assign tap_link[0] = signed'(s_tdata);
    assign acc_link[0] = '0;
    assign tag_link[0] = issue_tag;

    for (genvar j = 0; j < TAP_COUNT; j++)
    begin : g_cell
        ppu_tap_cell #(
            .TAP_COUNT      (TAP_COUNT),
            .MAX_FACTOR     (MAX_FACTOR),
            .OUTPUT_DIVISOR (OUTPUT_DIVISOR),
            .COEF_BITS      (COEF_BITS),
            .TAP_POS        (j),
            .ACC_W          (ACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (in_accept),
            .clear     (factor_write),
            .advance   (advance),
            .factor_m1 (factor_m1),
            .tap_in    (tap_link[j]),
            .tap_out   (tap_link[j+1]),
            .acc_in    (acc_link[j]),
            .acc_out   (acc_link[j+1]),
            .tag_in    (tag_link[j]),
            .tag_out   (tag_link[j+1])
        );
    end

    // ---------------------------------------------------------------
    // Round, saturate, count clips and hold the result for the consumer
    // ---------------------------------------------------------------
    ppu_out_stage #(
        .COEF_BITS (COEF_BITS),
        .ACC_W     (ACC_W)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (factor_write),
        .advance  (advance),
        .acc      (acc_link[TAP_COUNT]),
        .tag      (tag_link[TAP_COUNT]),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/ppu_tap_cell.sv]
// One cell of the tap chain: holds one history sample, its coefficient table,
// and one multiply-accumulate stage of the running dot product. Uses ppu_pkg.
`timescale 1ns / 1ps

module ppu_tap_cell
    import ppu_pkg::*;
#(
    parameter int TAP_COUNT      = DEF_TAP_COUNT,
    parameter int MAX_FACTOR     = DEF_MAX_FACTOR,
    parameter int OUTPUT_DIVISOR = DEF_OUTPUT_DIVISOR,
    parameter int COEF_BITS      = DEF_COEF_BITS,
    parameter int TAP_POS        = 0,
    parameter int ACC_W          = SAMPLE_W + COEF_BITS + $clog2(TAP_COUNT)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic                       clear,
    input  logic                       advance,
    input  logic [FACTOR_W-1:0]        factor_m1,
    input  logic signed [SAMPLE_W-1:0] tap_in,
    output logic signed [SAMPLE_W-1:0] tap_out,
    input  logic signed [ACC_W-1:0]    acc_in,
    output logic signed [ACC_W-1:0]    acc_out,
    input  ppu_tag_t                   tag_in,
    output ppu_tag_t                   tag_out
);

    localparam int ROM_DEPTH = 1 << ROM_ADDR_W;
    localparam int PROD_W    = SAMPLE_W + COEF_BITS;

    function automatic logic [ROM_DEPTH*COEF_BITS-1:0] build_rom();
        logic [ROM_DEPTH*COEF_BITS-1:0] bits;
        logic signed [31:0]             c;
        int                             f;
        int                             p;
        bits = '0;
        for (f = 1; f <= MAX_FACTOR; f++)
        begin
            for (p = 0; p < f; p++)
            begin
                c = coef_value(TAP_COUNT, COEF_BITS, OUTPUT_DIVISOR, f, p, TAP_POS);
                bits[(((f - 1) << PHASE_W) + p) * COEF_BITS +: COEF_BITS] = c[COEF_BITS-1:0];
            end
        end
        return bits;
    endfunction

    localparam logic [ROM_DEPTH*COEF_BITS-1:0] CELL_ROM = build_rom();

    logic signed [SAMPLE_W-1:0]  tap_reg;
    logic signed [SAMPLE_W-1:0]  tap_next;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    ppu_tag_t                    tag_reg;
    logic [ROM_ADDR_W-1:0]       rom_addr;
    logic signed [COEF_BITS-1:0] coef;
    logic signed [PROD_W-1:0]    prod;

    assign rom_addr = {factor_m1, tag_in.phase};
    assign coef     = signed'(CELL_ROM[rom_addr * COEF_BITS +: COEF_BITS]);
    assign prod     = tap_reg * coef;

    always_comb
    begin
        tap_next = tap_reg;
        if (clear)
        begin
            tap_next = '0;
        end
        else if (shift)
        begin
            tap_next = tap_in;
        end
        acc_next = acc_in + ACC_W'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            tag_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
            if (advance)
            begin
                tag_reg <= tag_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_reg <= acc_next;
        end
    end

    assign tap_out = tap_reg;
    assign acc_out = acc_reg;
    assign tag_out = tag_reg;

endmodule

[rtl/ppu_out_stage.sv]
// Output stage: rounds and saturates the chain sum, keeps the clip total,
// and holds the result register of the output stream. Uses ppu_pkg.
`timescale 1ns / 1ps

module ppu_out_stage
    import ppu_pkg::*;
#(
    parameter int COEF_BITS = DEF_COEF_BITS,
    parameter int ACC_W     = SAMPLE_W + COEF_BITS + 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    advance,
    input  logic signed [ACC_W-1:0] acc,
    input  ppu_tag_t                tag,
    output logic                    m_tvalid,
    output logic [OUT_DATA_W-1:0]   m_tdata,
    output logic [OUT_USER_W-1:0]   m_tuser,
    output logic                    m_tlast
);

    localparam int FRAC_BITS = COEF_BITS - 2;
    localparam logic signed [ACC_W-1:0] ACC_HI   = ACC_W'(SAMPLE_MAX) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_LO   = -(ACC_W'(SAMPLE_MIN_MAG) << FRAC_BITS);
    localparam logic [ACC_W-1:0]        ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic                       valid_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic                       last_reg;
    logic                       clipped_reg;
    logic [CLIP_W-1:0]          clip_total_reg;
    logic [CLIP_W-1:0]          clip_cnt_reg;
    logic [CLIP_W-1:0]          clip_cnt_next;
    logic                       clip_hi;
    logic                       clip_lo;
    logic [ACC_W-1:0]           mag;
    logic [ACC_W-1:0]           rnd;
    logic [SAMPLE_W-1:0]        sample_next;

    assign clip_hi = (acc > ACC_HI);
    assign clip_lo = (acc < ACC_LO);
    assign mag     = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign rnd     = (mag + ACC_HALF) >> FRAC_BITS;

    always_comb
    begin
        if (clip_hi)
        begin
            sample_next = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (clip_lo)
        begin
            sample_next = SAMPLE_W'(SAMPLE_MIN_MAG);
        end
        else if (acc[ACC_W-1])
        begin
            sample_next = -rnd[SAMPLE_W-1:0];
        end
        else
        begin
            sample_next = rnd[SAMPLE_W-1:0];
        end

        clip_cnt_next = clip_cnt_reg;
        if ((clip_hi || clip_lo) && clip_cnt_reg != '1)
        begin
            clip_cnt_next = clip_cnt_reg + CLIP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            clip_cnt_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= tag.valid;
            end
            if (clear)
            begin
                clip_cnt_reg <= '0;
            end
            else if (advance && tag.valid)
            begin
                clip_cnt_reg <= clip_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tag.valid)
        begin
            sample_reg     <= sample_next;
            phase_reg      <= tag.phase;
            last_reg       <= tag.last;
            clipped_reg    <= clip_hi || clip_lo;
            clip_total_reg <= clip_cnt_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {clip_total_reg, sample_reg};
    assign m_tuser  = {clipped_reg, phase_reg};
    assign m_tlast  = last_reg;

endmodule

[rtl/ppu_checker.sv]
// Port-level checker for the polyphase upsampler, bound to the top level.
// Uses ppu_pkg and the assertion macros of polyphase_pcm_upsampler_defines.svh.
`timescale 1ns / 1ps
`include "polyphase_pcm_upsampler_defines.svh"

module ppu_checker
    import ppu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser,
    input logic                  m_tlast
);

    // A stalled result holds
    `PPU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")

    // A taken sample closes the intake until its phases are out
    `PPU_ASSERT_NXT(a_intake_closes, s_tvalid && s_tready, !s_tready, "input ready right after a request")

    // A result that is not the final phase means a sample is still in flight
    `PPU_ASSERT_IMP(a_no_intake_mid_run, m_tvalid && !m_tlast, !s_tready, "input ready in the middle of a run")

    // A clipped result sits at a rail
    `PPU_ASSERT_IMP(a_clip_at_rail, m_tvalid && m_tuser[PHASE_W], m_tdata[SAMPLE_W-1:0] == 16'h7FFF || m_tdata[SAMPLE_W-1:0] == 16'h8000, "clipped output not at a rail")

    // A clipped result has been counted
    `PPU_ASSERT_IMP(a_clip_counted, m_tvalid && m_tuser[PHASE_W], m_tdata[OUT_DATA_W-1:SAMPLE_W] != '0, "clipped output with zero clip total")

endmodule

bind polyphase_pcm_upsampler ppu_checker u_ppu_checker (.*);

[test/upsampler_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the polyphase PCM upsampler: rebuilds the windowed-sinc tap
// table, predicts every phase output of each sample request and compares.
// Depends on ppu_pkg for widths, the register map and the window constants.

module upsampler_scoreboard
    import ppu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,     // [15:0] sample_in
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,     // [15:0] sample_out, [47:16] clip_total
    input  logic [OUT_USER_W-1:0] m_tuser,     // [2:0] phase_index, [3] clipped
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    outputs_due
);

    localparam int TAPS      = DEF_TAP_COUNT;
    localparam int MAXF      = DEF_MAX_FACTOR;
    localparam int FRAC      = DEF_COEF_BITS - 2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [PHASE_W-1:0]  phase;
        logic                last;
        logic                clipped;
        logic [CLIP_W-1:0]   clip_total;
    } phase_result_t;

    int                  sinc_taps [MAXF*MAXF*TAPS];
    int                  sample_line [TAPS];
    logic [CLIP_W-1:0]   clip_tally;
    logic [FACTOR_W-1:0] phase_count;
    phase_result_t       phase_outputs_due [$];

    function automatic int tap_slot(input int f, input int p, input int j);
        return ((f - 1) * MAXF + p) * TAPS + j;
    endfunction

    // sin(pi*m/span) in Q30, Taylor series with truncating steps
    function automatic longint unsigned sin_pi_q30(input longint unsigned m_in,
                                                   input longint unsigned span);
        longint unsigned m;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          total;
        int              k;
        m = m_in;
        if (span == 0 || m >= span)
        begin
            return 0;
        end
        if (2 * m > span)
        begin
            m = span - m;
        end
        x     = (PI_Q30 * m) / span;
        x2    = (x * x) >> 30;
        term  = x;
        total = longint'(x);
        for (k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            total = (k % 2 == 1) ? total - longint'(term) : total + longint'(term);
        end
        if (total < 0)
        begin
            total = 0;
        end
        if (total > (longint'(1) << 30))
        begin
            total = longint'(1) << 30;
        end
        return longint'(total);
    endfunction

    function automatic int round_coef(input longint unsigned mag, input bit neg,
                                      input longint unsigned den_in);
        longint unsigned den;
        longint unsigned q;
        longint unsigned lim;
        den = (den_in == 0) ? 1 : den_in;
        q   = ((mag << FRAC) + den / 2) / den;
        lim = longint'(1) << (DEF_COEF_BITS - 1);
        if (!neg)
        begin
            lim = lim - 1;
        end
        if (q > lim)
        begin
            q = lim;
        end
        return neg ? -int'(q) : int'(q);
    endfunction

    function automatic void build_sinc_taps();
        longint unsigned w [TAPS];
        bit              neg [TAPS];
        longint          total;
        longint unsigned an;
        longint unsigned den;
        int              n;
        int              f;
        int              p;
        int              j;
        for (j = 0; j < MAXF * MAXF * TAPS; j++)
        begin
            sinc_taps[j] = 0;
        end
        for (f = 1; f <= MAXF; f++)
        begin
            // phase 0 lands on the input lattice: one unity tap at the center
            sinc_taps[tap_slot(f, 0, CENTER_TAP)] = round_coef(1, 1'b0, DEF_OUTPUT_DIVISOR);
            for (p = 1; p < f; p++)
            begin
                total = 0;
                for (j = 0; j < TAPS; j++)
                begin
                    n      = (j - CENTER_TAP) * f + p;
                    an     = longint'((n < 0) ? -n : n);
                    w[j]   = 0;
                    neg[j] = 1'b0;
                    if (an != 0 && an < WINDOW_HALF * f)
                    begin
                        w[j]   = (sin_pi_q30(an, WINDOW_HALF * f) << 10) / (an * an);
                        neg[j] = (j % 2 == 1) != (n < 0);
                        total  = neg[j] ? total - longint'(w[j]) : total + longint'(w[j]);
                    end
                end
                den = (total > 0) ? longint'(total) * DEF_OUTPUT_DIVISOR : 1;
                for (j = 0; j < TAPS; j++)
                begin
                    sinc_taps[tap_slot(f, p, j)] = round_coef(w[j], neg[j], den);
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        fail_count++;
        $display("[%0t] upsampler mismatch: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic clear_history();
        int j;
        for (j = 0; j < TAPS; j++)
        begin
            sample_line[j] = 0;
        end
        clip_tally = '0;
    endtask

    // Shift one sample in and queue every phase it yields
    task automatic interpolate_sample(input logic [SAMPLE_W-1:0] raw);
        phase_result_t r;
        longint        acc;
        longint        mag;
        longint        rounded;
        int            y;
        int            p;
        int            j;
        bit            clip;
        for (j = TAPS - 1; j > 0; j--)
        begin
            sample_line[j] = sample_line[j-1];
        end
        sample_line[0] = int'($signed(raw));
        for (p = 0; p < int'(phase_count); p++)
        begin
            acc = 0;
            for (j = 0; j < TAPS; j++)
            begin
                acc += longint'(sample_line[j]) * sinc_taps[tap_slot(int'(phase_count), p, j)];
            end
            clip = 1'b1;
            if (acc > (longint'(SAMPLE_MAX) <<< FRAC))
            begin
                y = SAMPLE_MAX;
            end
            else if (acc < -(longint'(SAMPLE_MIN_MAG) <<< FRAC))
            begin
                y = -SAMPLE_MIN_MAG;
            end
            else
            begin
                clip    = 1'b0;
                mag     = (acc < 0) ? -acc : acc;
                rounded = (mag + (longint'(1) << (FRAC - 1))) >> FRAC;
                y       = (acc < 0) ? -int'(rounded) : int'(rounded);
            end
            if (clip && clip_tally != '1)
            begin
                clip_tally++;
            end
            r.sample     = y[SAMPLE_W-1:0];
            r.phase      = p[PHASE_W-1:0];
            r.last       = (p == int'(phase_count) - 1);
            r.clipped    = clip;
            r.clip_total = clip_tally;
            phase_outputs_due.push_back(r);
        end
    endtask

    initial
    begin
        build_sinc_taps();
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        phase_result_t due;
        if (!rst_n)
        begin
            fail_count  = 0;
            clear_history();
            phase_count = 3'd1;
            phase_outputs_due.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_UPSAMPLE_FACTOR)
            begin
                if (pwrite)
                begin
                    // out-of-range factors are dropped, valid ones restart the filter
                    if (pwdata[FACTOR_W-1:0] >= 1 && pwdata[FACTOR_W-1:0] <= MAXF)
                    begin
                        phase_count = pwdata[FACTOR_W-1:0];
                        clear_history();
                    end
                end
                else if (prdata != APB_DATA_W'(phase_count))
                begin
                    report_mismatch("upsample_factor read", prdata, phase_count);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (phase_outputs_due.size() == 0)
                begin
                    report_mismatch("output with nothing due", m_tdata, 0);
                end
                else
                begin
                    due = phase_outputs_due.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] != due.sample)
                    begin
                        report_mismatch("sample_out", m_tdata[SAMPLE_W-1:0], due.sample);
                    end
                    if (m_tuser[PHASE_W-1:0] != due.phase)
                    begin
                        report_mismatch("phase_index", m_tuser[PHASE_W-1:0], due.phase);
                    end
                    if (m_tlast != due.last)
                    begin
                        report_mismatch("last", m_tlast, due.last);
                    end
                    if (m_tuser[PHASE_W] != due.clipped)
                    begin
                        report_mismatch("clipped", m_tuser[PHASE_W], due.clipped);
                    end
                    if (m_tdata[OUT_DATA_W-1:SAMPLE_W] != due.clip_total)
                    begin
                        report_mismatch("clip_total", m_tdata[OUT_DATA_W-1:SAMPLE_W],
                                        due.clip_total);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                interpolate_sample(s_tdata);
            end
        end
        outputs_due = phase_outputs_due.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the upsampler testbench: clock, reset, sample requests, output
// back-pressure and register traffic, plus the final verdict.
// Depends on ppu_pkg, polyphase_pcm_upsampler and upsampler_scoreboard.

module testbench;
    import ppu_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 12;
    // after the last output the tap chain may still hold a phase in flight
    localparam int SETTLE_CYCLES = DEF_TAP_COUNT + DEF_MAX_FACTOR + 16;
    localparam int RUN_LIMIT_NS  = 2000000;
    localparam int PLAN_LEN      = 8;

    localparam logic [APB_ADDR_W-1:0] FACTOR_ADDR = APB_ADDR_W'(4 * REG_UPSAMPLE_FACTOR);
    // one slot past the register map: writes there must change nothing
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = APB_ADDR_W'(4 * (REG_UPSAMPLE_FACTOR + 1));

    localparam logic [SAMPLE_W-1:0] FULL_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] FULL_NEG = 16'h8000;
    localparam logic [FACTOR_W-1:0] FACTOR_ZERO = 3'd0;
    localparam logic [FACTOR_W-1:0] FACTOR_OVER = 3'd7;

    typedef enum int {PAT_NOISE, PAT_SQUARE, PAT_QUIET, PAT_IMPULSE, PAT_RAMP} pattern_e;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;     // [15:0] sample_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // [15:0] sample_out, [47:16] clip_total
    logic [OUT_USER_W-1:0] m_tuser;     // [2:0] phase_index, [3] clipped
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int outputs_due;
    bit idle_on;

    always #(CLK_PERIOD / 2) clk = ~clk;

    polyphase_pcm_upsampler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    upsampler_scoreboard score (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outputs_due (outputs_due)
    );

    // One APB transfer: setup, access until pready, then a return to bus idle so
    // that back-to-back transfers never drive psel twice in one step.
    task automatic apb_access(input bit write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one sample request; sometimes hold valid low for a burst first.
    // Valid stays up after acceptance so the next request follows at once.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid and wait until every predicted phase has come out, then let
    // the chain run dry before anyone touches the factor register.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outputs_due != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random samples in short bursts of one signal shape each: wide noise,
    // full-swing squares that ring past full scale, quiet passages, lone
    // impulses and wrapping ramps.
    task automatic send_run(input int count);
        pattern_e            shape;
        logic [SAMPLE_W-1:0] value;
        logic [SAMPLE_W-1:0] origin;
        logic [SAMPLE_W-1:0] stride;
        int                  left;
        int                  burst;
        int                  k;
        left = count;
        while (left > 0)
        begin
            burst  = $urandom_range(1, 10);
            burst  = (burst > left) ? left : burst;
            shape  = pattern_e'($urandom_range(0, 4));
            origin = 16'($urandom_range(0, 16'hFFFF));
            stride = 16'($urandom_range(0, 16'h0FFF));
            for (k = 0; k < burst; k++)
            begin
                case (shape)
                    PAT_NOISE:   value = 16'($urandom_range(0, 16'hFFFF));
                    PAT_SQUARE:  value = (k % 2 == 1) ? FULL_NEG : FULL_POS;
                    PAT_QUIET:   value = 16'($urandom_range(0, 600) - 300);
                    PAT_IMPULSE: value = (k != 0) ? 16'h0000 : origin[0] ? FULL_NEG : FULL_POS;
                    default:     value = origin + 16'(k) * stride;
                endcase
                send_sample(value);
            end
            left -= burst;
        end
    endtask

    // Output back-pressure: random stall bursts while idling is on,
    // otherwise always ready.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!idle_on)
            begin
                stall_left = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int                  factor_plan [PLAN_LEN];
        int                  i;
        logic [FACTOR_W-1:0] junk;
        factor_plan = '{3, 1, 5, 2, 6, 4, 1, 6};
        idle_on  = 1'b1;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset factor of one: each output is the sample from eight requests back
        apb_access(1'b0, FACTOR_ADDR, '0);
        send_sample(FULL_POS);
        send_sample(FULL_NEG);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        settle();

        // Widest factor: walk a full-scale impulse down the taps to expose
        // every phase's coefficients, then a full-swing square to force clipping
        apb_access(1'b1, FACTOR_ADDR, APB_DATA_W'(DEF_MAX_FACTOR));
        apb_access(1'b0, FACTOR_ADDR, '0);
        send_sample(FULL_POS);
        repeat (7) send_sample(16'h0000);
        for (i = 0; i < 8; i++)
        begin
            send_sample((i % 2 == 1) ? FULL_NEG : FULL_POS);
        end
        settle();

        // Writes that must be dropped: zero, above range, and an unmapped slot
        apb_access(1'b1, FACTOR_ADDR, APB_DATA_W'(FACTOR_ZERO));
        apb_access(1'b1, FACTOR_ADDR, APB_DATA_W'(FACTOR_OVER));
        apb_access(1'b1, SPARE_ADDR, 32'd3);
        apb_access(1'b0, FACTOR_ADDR, '0);
        send_sample(FULL_NEG);
        send_sample(FULL_POS);
        settle();

        // Rewrite the same factor with junk in the upper bits: history and
        // clip total must restart from zero
        apb_access(1'b1, FACTOR_ADDR, {29'h1FFF_FFFF, 3'(DEF_MAX_FACTOR)});
        send_sample(FULL_POS);
        send_sample(FULL_NEG);
        settle();

        // Random phases over a spread of factors; the last one runs flat out
        for (i = 0; i < PLAN_LEN; i++)
        begin
            idle_on = (i != PLAN_LEN - 1) && ($urandom_range(0, 3) != 0);
            apb_access(1'b1, FACTOR_ADDR,
                       ($urandom() & ~APB_DATA_W'(7)) | APB_DATA_W'(factor_plan[i]));
            if ($urandom_range(0, 1) == 1)
            begin
                junk = $urandom_range(0, 1) ? FACTOR_OVER : FACTOR_ZERO;
                apb_access(1'b1, FACTOR_ADDR,
                           ($urandom() & ~APB_DATA_W'(7)) | APB_DATA_W'(junk));
                apb_access(1'b1, SPARE_ADDR, $urandom());
            end
            apb_access(1'b0, FACTOR_ADDR, '0);
            send_run($urandom_range(18, 28));
            settle();
        end

        if (fail_count == 0 && outputs_due == 0)
        begin
            $display("** polyphase_pcm_upsampler: PASSED **");
        end
        else
        begin
            $display("** polyphase_pcm_upsampler: FAILED **");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("** polyphase_pcm_upsampler: FAILED **");
        $finish;
    end

endmodule
